>>> hdl/tcl_pkg.sv
// ----------------------------------------------------------------------------
// tcl_pkg
// Shared constants, types and table helpers for the temperature
// compensation lookup.
// ----------------------------------------------------------------------------
package tcl_pkg;

    localparam int WINDOW_LEN     = 6;
    localparam int TABLE_ENTRIES  = 4;
    localparam int NUM_SYSTEMS    = 3;
    localparam int NUM_DIRECTIONS = 2;

    localparam int WP_W    = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int ENTRY_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int SYS_W   = (NUM_SYSTEMS > 1) ? $clog2(NUM_SYSTEMS) : 1;

    localparam int PACKED_ENTRIES = 4;
    localparam int MASK_BITS      = 3;
    localparam int UPDATE_SPREAD  = 3;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLDS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UP_GAINS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DOWN_GAINS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UP_POWERS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DOWN_POWERS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SYSTEM_MASK = 3'd5;

    localparam logic [31:0] THRESHOLDS_RESET  = 32'h7F41_2D0A;
    localparam logic [31:0] UP_GAINS_RESET    = 32'hFDFE_0001;
    localparam logic [31:0] DOWN_GAINS_RESET  = 32'hFDFF_0001;
    localparam logic [31:0] UP_POWERS_RESET   = 32'h0000_0000;
    localparam logic [31:0] DOWN_POWERS_RESET = 32'h0000_0000;
    localparam logic [MASK_BITS-1:0] SYSTEM_MASK_RESET = 3'd7;

    localparam logic signed [7:0] IN_USE_RESET = -8'sd128;

    typedef struct packed {
        logic [31:0]           thresholds;
        logic [31:0]           up_gains;
        logic [31:0]           down_gains;
        logic [31:0]           up_powers;
        logic [31:0]           down_powers;
        logic [MASK_BITS-1:0]  system_mask;
    } cfg_regs_t;

    typedef struct packed {
        logic               start;
        logic [ENTRY_W-1:0] entry;
    } run_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } run_status_t;

    function automatic logic signed [7:0] packed_byte(logic [31:0] word, int idx);
        logic signed [7:0] r;
        r = '0;
        for (int i = 0; i < PACKED_ENTRIES; i++)
        begin
            if (idx == i)
            begin
                r = word[8*i +: 8];
            end
        end
        return r;
    endfunction

    function automatic logic [ENTRY_W-1:0] lookup_entry(logic signed [7:0] t,
                                                        logic [31:0] thr);
        logic [ENTRY_W-1:0] e;
        e = ENTRY_W'(TABLE_ENTRIES - 1);
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
        begin
            if (t <= packed_byte(thr, i))
            begin
                e = ENTRY_W'(i);
            end
        end
        return e;
    endfunction

endpackage

>>> hdl/tcl_cfg.sv
// ----------------------------------------------------------------------------
// tcl_cfg
// Configuration register file for thresholds, offsets and enable mask.
// ----------------------------------------------------------------------------
module tcl_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tcl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data,
    output tcl_pkg::cfg_regs_t            regs
);

    tcl_pkg::cfg_regs_t regs_reg;

    assign cfg_ready = 1'b1;
    assign regs      = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.thresholds  <= tcl_pkg::THRESHOLDS_RESET;
            regs_reg.up_gains    <= tcl_pkg::UP_GAINS_RESET;
            regs_reg.down_gains  <= tcl_pkg::DOWN_GAINS_RESET;
            regs_reg.up_powers   <= tcl_pkg::UP_POWERS_RESET;
            regs_reg.down_powers <= tcl_pkg::DOWN_POWERS_RESET;
            regs_reg.system_mask <= tcl_pkg::SYSTEM_MASK_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                tcl_pkg::REG_THRESHOLDS:  regs_reg.thresholds  <= cfg_data;
                tcl_pkg::REG_UP_GAINS:    regs_reg.up_gains    <= cfg_data;
                tcl_pkg::REG_DOWN_GAINS:  regs_reg.down_gains  <= cfg_data;
                tcl_pkg::REG_UP_POWERS:   regs_reg.up_powers   <= cfg_data;
                tcl_pkg::REG_DOWN_POWERS: regs_reg.down_powers <= cfg_data;
                tcl_pkg::REG_SYSTEM_MASK:
                    regs_reg.system_mask <= cfg_data[tcl_pkg::MASK_BITS-1:0];
                default: ;
            endcase
        end
    end

endmodule

>>> hdl/tcl_window.sv
// ----------------------------------------------------------------------------
// tcl_window
// Sample window, update decision and table entry search per transaction.
// ----------------------------------------------------------------------------
module tcl_window (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    accept,
    input  logic signed [7:0]       temperature,
    input  logic [31:0]             thresholds,
    output tcl_pkg::run_req_t       req
);

    logic signed [7:0]         window_reg [tcl_pkg::WINDOW_LEN];
    logic signed [7:0]         window_next [tcl_pkg::WINDOW_LEN];
    logic [tcl_pkg::WP_W-1:0]  wp_reg;
    logic [tcl_pkg::WP_W-1:0]  wp_next;
    logic signed [7:0]         in_use_reg;
    logic signed [7:0]         mx;
    logic signed [7:0]         mn;
    logic                      all_equal;
    logic signed [8:0]         spread;
    logic signed [8:0]         diff;
    logic                      update;

    always_comb
    begin
        if (wp_reg == tcl_pkg::WP_W'(tcl_pkg::WINDOW_LEN - 1))
            wp_next = '0;
        else
            wp_next = wp_reg + 1'b1;

        for (int i = 0; i < tcl_pkg::WINDOW_LEN; i++)
        begin
            window_next[i] = (wp_next == tcl_pkg::WP_W'(i)) ? temperature : window_reg[i];
        end

        mx        = window_next[0];
        mn        = window_next[0];
        all_equal = 1'b1;
        for (int i = 1; i < tcl_pkg::WINDOW_LEN; i++)
        begin
            if (window_next[i] > mx)
                mx = window_next[i];
            if (window_next[i] < mn)
                mn = window_next[i];
            if (window_next[i] != window_next[0])
                all_equal = 1'b0;
        end

        spread = 9'(mx) - 9'(mn);
        diff   = 9'(temperature) - 9'(in_use_reg);
        update = all_equal
              || (spread >= 9'(tcl_pkg::UPDATE_SPREAD))
              || (diff > 9'(tcl_pkg::UPDATE_SPREAD))
              || (diff < -9'(tcl_pkg::UPDATE_SPREAD));
    end

    assign req.start = accept && update;
    assign req.entry = tcl_pkg::lookup_entry(temperature, thresholds);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < tcl_pkg::WINDOW_LEN; i++)
            begin
                window_reg[i] <= '0;
            end
            wp_reg     <= '0;
            in_use_reg <= tcl_pkg::IN_USE_RESET;
        end
        else if (accept)
        begin
            for (int i = 0; i < tcl_pkg::WINDOW_LEN; i++)
            begin
                window_reg[i] <= window_next[i];
            end
            wp_reg <= wp_next;
            if (update)
                in_use_reg <= temperature;
        end
    end

endmodule

>>> hdl/tcl_emit.sv
// ----------------------------------------------------------------------------
// tcl_emit
// Result sequencer: one result per system and direction for each update.
// ----------------------------------------------------------------------------
module tcl_emit (
    input  logic                clk,
    input  logic                rst_n,
    input  tcl_pkg::run_req_t   req,
    input  tcl_pkg::cfg_regs_t  regs,
    input  logic                out_stall,
    output logic                out_valid,
    output logic [1:0]          system_index,
    output logic                direction,
    output logic signed [7:0]   gain_offset,
    output logic signed [7:0]   power_offset,
    output logic                last,
    output tcl_pkg::run_status_t status
);

    logic                        active_reg;
    logic [tcl_pkg::SYS_W-1:0]   sys_reg;
    logic                        dir_reg;
    logic [tcl_pkg::ENTRY_W-1:0] entry_reg;
    logic                        dir_last;
    logic                        run_last;
    logic                        take;
    logic                        en;
    logic signed [7:0]           g;
    logic signed [7:0]           p;

    assign dir_last = (dir_reg == 1'(tcl_pkg::NUM_DIRECTIONS - 1));
    assign run_last = dir_last && (sys_reg == tcl_pkg::SYS_W'(tcl_pkg::NUM_SYSTEMS - 1));
    assign take     = active_reg && !out_stall;

    always_comb
    begin
        en = 1'b0;
        for (int i = 0; i < tcl_pkg::MASK_BITS; i++)
        begin
            if (int'(sys_reg) == i)
                en = regs.system_mask[i];
        end
        if (dir_reg)
        begin
            g = tcl_pkg::packed_byte(regs.down_gains, int'(entry_reg));
            p = tcl_pkg::packed_byte(regs.down_powers, int'(entry_reg));
        end
        else
        begin
            g = tcl_pkg::packed_byte(regs.up_gains, int'(entry_reg));
            p = tcl_pkg::packed_byte(regs.up_powers, int'(entry_reg));
        end
    end

    assign out_valid    = active_reg;
    assign system_index = 2'(sys_reg);
    assign direction    = dir_reg;
    assign gain_offset  = en ? g : 8'sd0;
    assign power_offset = en ? p : 8'sd0;
    assign last         = run_last;

    assign status.busy = active_reg;
    assign status.done = take && run_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            sys_reg    <= '0;
            dir_reg    <= 1'b0;
        end
        else if (req.start)
        begin
            active_reg <= 1'b1;
            sys_reg    <= '0;
            dir_reg    <= 1'b0;
        end
        else if (take)
        begin
            if (run_last)
            begin
                active_reg <= 1'b0;
            end
            else if (dir_last)
            begin
                dir_reg <= 1'b0;
                sys_reg <= sys_reg + 1'b1;
            end
            else
            begin
                dir_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
            entry_reg <= req.entry;
    end

endmodule

>>> hdl/temperature_compensation_lookup.sv
// ----------------------------------------------------------------------------
// temperature_compensation_lookup
// Windowed temperature update decision with table lookup of gain and power
// compensation offsets per radio system and link direction.
// ----------------------------------------------------------------------------
// first result: out_valid is registered and is set in the cycle after the sample transaction
// throughput: one sample per cycle when no update follows; an update emits
//   NUM_SYSTEMS * NUM_DIRECTIONS results, one per cycle while out_stall is low,
//   from the result sequencer, and the next sample is taken with the last of them
// reset: asynchronous, clears window and position, sets the in-use temperature
//   to -128 and loads the register defaults
module temperature_compensation_lookup (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [7:0]             temperature,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    system_index,
    output logic                          direction,
    output logic signed [7:0]             gain_offset,
    output logic signed [7:0]             power_offset,
    output logic                          last,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tcl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data
);

    tcl_pkg::cfg_regs_t   regs;
    tcl_pkg::run_req_t    req;
    tcl_pkg::run_status_t status;
    logic                 accept;

    assign in_stall = status.busy && !status.done;
    assign accept   = in_valid && !in_stall;

    tcl_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .regs      (regs)
    );

    tcl_window u_window (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .temperature (temperature),
        .thresholds  (regs.thresholds),
        .req         (req)
    );

    tcl_emit u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req),
        .regs         (regs),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .system_index (system_index),
        .direction    (direction),
        .gain_offset  (gain_offset),
        .power_offset (power_offset),
        .last         (last),
        .status       (status)
    );

endmodule
